// File: rtl/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg: shared types and constants of the escape sequence decoder
// Result codes, decoder modes, character codes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package esd_pkg;

    // Result status codes carried on the output channel.
    typedef enum logic [1:0] {
        ST_BYTE  = 2'd0,
        ST_END   = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    // Decoder modes.
    typedef enum logic [2:0] {
        MODE_NORMAL    = 3'd0,
        MODE_CARET     = 3'd1,
        MODE_BSLASH    = 3'd2,
        MODE_OCT_FIRST = 3'd3,
        MODE_OCT       = 3'd4,
        MODE_HEX_FIRST = 3'd5,
        MODE_HEX       = 3'd6,
        MODE_DISCARD   = 3'd7
    } mode_t;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic [7:0] length;
        logic       last;
    } result_t;

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_CARET  = 8'h5e;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_ESC    = 8'h1b;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0b;
    localparam logic [7:0] CTRL_MASK = 8'h1f;
    localparam logic [7:0] BYTE_MAX  = 8'hff;

endpackage

`default_nettype wire

// File: rtl/esd_in_if.sv
// ----------------------------------------------------------------------------
// esd_in_if: source character channel
// Valid/ready channel that carries one source byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/esd_out_if.sv
// ----------------------------------------------------------------------------
// esd_out_if: decoded result channel
// Valid/ready channel that carries one decoded result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface esd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic [7:0] length;
    logic       last;

    modport source (output valid, output out_byte, output status, output length,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input status, input length,
                    input last, output ready);
endinterface

`default_nettype wire

// File: rtl/escape_sequence_decoder_top.sv
// ----------------------------------------------------------------------------
// escape_sequence_decoder_top: caret and backslash escape decoder
// Decodes a zero-terminated character stream into bytes and end/error status.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one source byte per transaction; a zero byte ends a string.
//   out_ch carries results: a decoded byte (status 0), an end of string with
//   the saturated length (status 1) or a bad escape (status 2). The flag last
//   marks the final result caused by one source byte; a byte may cause none,
//   one or two results.
//   A byte accepted on in_ch sits in the input register, is decoded into
//   the result queue once the queue can take two results, and its first
//   result is offered on out_ch from then on.
//   Throughput: one byte per cycle while out_ch takes one result per cycle
//   and the queue keeps room for two results. A byte that causes two
//   results leaves one extra result in the queue. The four-entry result
//   queue absorbs one such byte; beyond that the input pauses for each one.
//   When out_ch stalls, up to four results wait in the queue and one byte in
//   the input register; in_ch.ready drops once the queue cannot take two.
//   Reset returns the decoder to normal mode with an empty queue, a cleared
//   accumulator and a zero byte count.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_decoder_top (
    input  wire        clk,
    input  wire        rst_n,
    esd_in_if.sink     in_ch,
    esd_out_if.source  out_ch
);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Decoder state.
    esd_pkg::mode_t mode_reg, mode_next;
    logic [7:0] acc_reg, acc_next;
    logic [1:0] dcnt_reg, dcnt_next;
    logic [7:0] bcnt_reg, bcnt_next;

    // Input register.
    logic       stg_valid_reg;
    logic [7:0] stg_byte_reg;
    logic       stg_move;

    // Result queue.
    esd_pkg::result_t q_mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     count_reg;
    logic             q_pop;

    // Decode outputs.
    esd_pkg::result_t res [2];
    logic [1:0]       n_res;
    logic             do_normal;
    logic [4:0]       hex_dec;
    logic [2:0]       dcnt_inc;
    logic [7:0]       oct_sum;
    logic [7:0]       hex_sum;
    logic             is_dig09;
    logic             is_oct;
    logic [7:0]       c;

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            r = {1'b1, ch[3:0]};
        end
        else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46))
        begin
            r = {1'b1, ch[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == esd_pkg::BYTE_MAX) ? v : v + 8'd1;
    endfunction

    assign c        = stg_byte_reg;
    assign is_dig09 = (c >= esd_pkg::CH_ZERO) && (c <= esd_pkg::CH_NINE);
    assign is_oct   = (c >= esd_pkg::CH_ZERO) && (c <= esd_pkg::CH_SEVEN);
    assign hex_dec  = hex_decode(c);
    assign dcnt_inc = {1'b0, dcnt_reg} + 3'd1;
    assign oct_sum  = {acc_reg[4:0], 3'b000} + {5'd0, c[2:0]};
    assign hex_sum  = {acc_reg[3:0], hex_dec[3:0]};

    // Handshake control: decode only when the queue can take two results.
    assign stg_move     = stg_valid_reg && (count_reg <= (QAW+1)'(QDEPTH - 2));
    assign in_ch.ready  = !stg_valid_reg || stg_move;
    assign q_pop        = out_ch.valid && out_ch.ready;

    // Decode one byte into up to two results and the next state.
    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        dcnt_next = dcnt_reg;
        bcnt_next = bcnt_reg;
        do_normal = 1'b0;
        n_res     = 2'd0;
        res[0]    = '0;
        res[1]    = '0;

        unique case (mode_reg)
            esd_pkg::MODE_CARET:
            begin
                if (c == esd_pkg::CH_NUL)
                begin
                    res[0]    = '{8'd0, esd_pkg::ST_ERROR, 8'd0, 1'b0};
                    n_res     = 2'd1;
                    bcnt_next = 8'd0;
                    acc_next  = 8'd0;
                    dcnt_next = 2'd0;
                    mode_next = esd_pkg::MODE_NORMAL;
                end
                else
                begin
                    res[0] = '{(c == esd_pkg::CH_CARET) ? c : (c & esd_pkg::CTRL_MASK),
                               esd_pkg::ST_BYTE, 8'd0, 1'b0};
                    n_res     = 2'd1;
                    bcnt_next = sat_inc(bcnt_reg);
                    mode_next = esd_pkg::MODE_NORMAL;
                end
            end
            esd_pkg::MODE_BSLASH:
            begin
                mode_next = esd_pkg::MODE_NORMAL;
                n_res     = 2'd1;
                bcnt_next = sat_inc(bcnt_reg);
                res[0]    = '{c, esd_pkg::ST_BYTE, 8'd0, 1'b0};
                unique case (c)
                    esd_pkg::CH_NUL:
                    begin
                        res[0]    = '{8'd0, esd_pkg::ST_ERROR, 8'd0, 1'b0};
                        bcnt_next = 8'd0;
                        acc_next  = 8'd0;
                        dcnt_next = 2'd0;
                    end
                    8'h65, 8'h45: res[0].out_byte = esd_pkg::CH_ESC;
                    8'h62, 8'h42: res[0].out_byte = esd_pkg::CH_BS;
                    8'h72, 8'h52: res[0].out_byte = esd_pkg::CH_CR;
                    8'h6e, 8'h4e: res[0].out_byte = esd_pkg::CH_LF;
                    8'h66, 8'h46: res[0].out_byte = esd_pkg::CH_FF;
                    8'h73, 8'h53: res[0].out_byte = esd_pkg::CH_SPACE;
                    8'h74, 8'h54: res[0].out_byte = esd_pkg::CH_TAB;
                    8'h76, 8'h56: res[0].out_byte = esd_pkg::CH_VT;
                    esd_pkg::CH_ZERO:
                    begin
                        n_res     = 2'd0;
                        bcnt_next = bcnt_reg;
                        acc_next  = 8'd0;
                        dcnt_next = 2'd0;
                        mode_next = esd_pkg::MODE_OCT_FIRST;
                    end
                    8'h78, 8'h58:
                    begin
                        n_res     = 2'd0;
                        bcnt_next = bcnt_reg;
                        acc_next  = 8'd0;
                        dcnt_next = 2'd0;
                        mode_next = esd_pkg::MODE_HEX_FIRST;
                    end
                    default: ;
                endcase
            end
            esd_pkg::MODE_OCT_FIRST, esd_pkg::MODE_OCT:
            begin
                priority if (mode_reg == esd_pkg::MODE_OCT_FIRST && !is_dig09)
                begin
                    res[0]    = '{8'd0, esd_pkg::ST_ERROR, 8'd0, 1'b0};
                    n_res     = 2'd1;
                    bcnt_next = 8'd0;
                    acc_next  = 8'd0;
                    dcnt_next = 2'd0;
                    mode_next = (c == esd_pkg::CH_NUL) ? esd_pkg::MODE_NORMAL
                                                       : esd_pkg::MODE_DISCARD;
                end
                else if (is_oct)
                begin
                    if (dcnt_inc >= 3'd3)
                    begin
                        res[0]    = '{oct_sum, esd_pkg::ST_BYTE, 8'd0, 1'b0};
                        n_res     = 2'd1;
                        bcnt_next = sat_inc(bcnt_reg);
                        acc_next  = 8'd0;
                        dcnt_next = 2'd0;
                        mode_next = esd_pkg::MODE_NORMAL;
                    end
                    else
                    begin
                        acc_next  = oct_sum;
                        dcnt_next = dcnt_inc[1:0];
                        mode_next = esd_pkg::MODE_OCT;
                    end
                end
                else
                begin
                    // Run ended by another character: flush, then handle it.
                    res[0]    = '{acc_reg, esd_pkg::ST_BYTE, 8'd0, 1'b0};
                    n_res     = 2'd1;
                    bcnt_next = sat_inc(bcnt_reg);
                    acc_next  = 8'd0;
                    dcnt_next = 2'd0;
                    mode_next = esd_pkg::MODE_NORMAL;
                    do_normal = 1'b1;
                end
            end
            esd_pkg::MODE_HEX_FIRST, esd_pkg::MODE_HEX:
            begin
                priority if (mode_reg == esd_pkg::MODE_HEX_FIRST && !hex_dec[4])
                begin
                    res[0]    = '{8'd0, esd_pkg::ST_ERROR, 8'd0, 1'b0};
                    n_res     = 2'd1;
                    bcnt_next = 8'd0;
                    acc_next  = 8'd0;
                    dcnt_next = 2'd0;
                    mode_next = (c == esd_pkg::CH_NUL) ? esd_pkg::MODE_NORMAL
                                                       : esd_pkg::MODE_DISCARD;
                end
                else if (hex_dec[4])
                begin
                    if (dcnt_inc >= 3'd2)
                    begin
                        res[0]    = '{hex_sum, esd_pkg::ST_BYTE, 8'd0, 1'b0};
                        n_res     = 2'd1;
                        bcnt_next = sat_inc(bcnt_reg);
                        acc_next  = 8'd0;
                        dcnt_next = 2'd0;
                        mode_next = esd_pkg::MODE_NORMAL;
                    end
                    else
                    begin
                        acc_next  = hex_sum;
                        dcnt_next = dcnt_inc[1:0];
                        mode_next = esd_pkg::MODE_HEX;
                    end
                end
                else
                begin
                    res[0]    = '{acc_reg, esd_pkg::ST_BYTE, 8'd0, 1'b0};
                    n_res     = 2'd1;
                    bcnt_next = sat_inc(bcnt_reg);
                    acc_next  = 8'd0;
                    dcnt_next = 2'd0;
                    mode_next = esd_pkg::MODE_NORMAL;
                    do_normal = 1'b1;
                end
            end
            esd_pkg::MODE_DISCARD:
            begin
                if (c == esd_pkg::CH_NUL)
                begin
                    mode_next = esd_pkg::MODE_NORMAL;
                    bcnt_next = 8'd0;
                end
            end
            esd_pkg::MODE_NORMAL:
            begin
                do_normal = 1'b1;
            end
        endcase

        // Normal-mode handling, also used after a run is flushed.
        if (do_normal)
        begin
            priority if (c == esd_pkg::CH_NUL)
            begin
                res[n_res[0]] = '{8'd0, esd_pkg::ST_END, bcnt_next, 1'b0};
                n_res         = n_res + 2'd1;
                bcnt_next     = 8'd0;
                mode_next     = esd_pkg::MODE_NORMAL;
            end
            else if (c == esd_pkg::CH_CARET)
            begin
                mode_next = esd_pkg::MODE_CARET;
            end
            else if (c == esd_pkg::CH_BSLASH)
            begin
                mode_next = esd_pkg::MODE_BSLASH;
            end
            else
            begin
                res[n_res[0]] = '{c, esd_pkg::ST_BYTE, 8'd0, 1'b0};
                n_res         = n_res + 2'd1;
                bcnt_next     = sat_inc(bcnt_next);
                mode_next     = esd_pkg::MODE_NORMAL;
            end
        end

        // Mark the final result of this byte.
        if (n_res == 2'd2)
        begin
            res[1].last = 1'b1;
        end
        else if (n_res == 2'd1)
        begin
            res[0].last = 1'b1;
        end
    end

    // Input register and decoder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            mode_reg      <= esd_pkg::MODE_NORMAL;
            acc_reg       <= 8'd0;
            dcnt_reg      <= 2'd0;
            bcnt_reg      <= 8'd0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                stg_valid_reg <= in_ch.valid;
            end
            if (stg_move)
            begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
                dcnt_reg <= dcnt_next;
                bcnt_reg <= bcnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            stg_byte_reg <= in_ch.in_byte;
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (stg_move)
            begin
                wr_ptr_reg <= wr_ptr_reg + n_res[QAW-1:0];
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + {{(QAW-1){1'b0}}, 1'b1};
            end
            count_reg <= count_reg + (stg_move ? {{(QAW-1){1'b0}}, n_res} : '0)
                         - {{QAW{1'b0}}, q_pop};
        end
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (stg_move && n_res != 2'd0)
        begin
            q_mem[wr_ptr_reg] <= res[0];
        end
        if (stg_move && n_res == 2'd2)
        begin
            q_mem[wr_ptr_reg + {{(QAW-1){1'b0}}, 1'b1}] <= res[1];
        end
    end

    // Output channel.
    assign out_ch.valid    = (count_reg != '0);
    assign out_ch.out_byte = q_mem[rd_ptr_reg].out_byte;
    assign out_ch.status   = q_mem[rd_ptr_reg].status;
    assign out_ch.length   = q_mem[rd_ptr_reg].length;
    assign out_ch.last     = q_mem[rd_ptr_reg].last;

endmodule

`default_nettype wire

// File: tb/tb_escape_sequence_decoder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_escape_sequence_decoder_top: self-checking bench for the escape decoder
// Drives zero-terminated strings with caret, backslash, octal and hex escapes.
// A decode predictor in the bench computes the expected results of each
// accepted byte. Every result transaction is checked field by field against
// the oldest expected result while both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_escape_sequence_decoder_top;

    localparam int         CLK_HALF      = 4;
    localparam int         RESET_CYCLES  = 10;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         REPORT_MAX    = 10;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         HOLD_CYCLES   = 200;
    localparam logic [7:0] CASE_BIT      = 8'h20;

    logic clk;
    logic rst_n;
    logic rx_hold;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   mismatch_count;
    int   decoded_inputs;

    // Decoder state as the predictor sees it.
    esd_pkg::mode_t dec_mode;
    logic [7:0]     dec_acc;
    logic [1:0]     dec_digits;
    logic [7:0]     dec_count;

    // Results still owed by the decoder, oldest first.
    esd_pkg::result_t expected_results[$];

    logic [7:0] escape_letters [8] = '{"e", "b", "r", "n", "f", "s", "t", "v"};

    esd_in_if  in_ch ();
    esd_out_if out_ch ();

    escape_sequence_decoder_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Decode predictor
    // ------------------------------------------------------------------------

    function automatic void push_result(input logic [7:0] value,
                                        input esd_pkg::status_t st,
                                        input logic [7:0] len);
        esd_pkg::result_t r;
        r.out_byte = value;
        r.status   = st;
        r.length   = len;
        r.last     = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic void emit_byte(input logic [7:0] value);
        push_result(value, esd_pkg::ST_BYTE, 8'h00);
        if (dec_count != esd_pkg::BYTE_MAX)
        begin
            dec_count = dec_count + 8'd1;
        end
    endfunction

    // A bad escape drops the rest of the string unless it is the terminator.
    function automatic void emit_error(input logic [7:0] ch);
        push_result(8'h00, esd_pkg::ST_ERROR, 8'h00);
        dec_count  = 8'h00;
        dec_acc    = 8'h00;
        dec_digits = 2'd0;
        if (ch == esd_pkg::CH_NUL)
        begin
            dec_mode = esd_pkg::MODE_NORMAL;
        end
        else
        begin
            dec_mode = esd_pkg::MODE_DISCARD;
        end
    endfunction

    function automatic void plain_char(input logic [7:0] ch);
        if (ch == esd_pkg::CH_NUL)
        begin
            push_result(8'h00, esd_pkg::ST_END, dec_count);
            dec_count = 8'h00;
            dec_mode  = esd_pkg::MODE_NORMAL;
        end
        else if (ch == esd_pkg::CH_CARET)
        begin
            dec_mode = esd_pkg::MODE_CARET;
        end
        else if (ch == esd_pkg::CH_BSLASH)
        begin
            dec_mode = esd_pkg::MODE_BSLASH;
        end
        else
        begin
            emit_byte(ch);
            dec_mode = esd_pkg::MODE_NORMAL;
        end
    endfunction

    function automatic void flush_run();
        emit_byte(dec_acc);
        dec_acc    = 8'h00;
        dec_digits = 2'd0;
        dec_mode   = esd_pkg::MODE_NORMAL;
    endfunction

    function automatic int hex_digit_value(input logic [7:0] ch);
        if (ch >= esd_pkg::CH_ZERO && ch <= esd_pkg::CH_NINE)
        begin
            return int'(ch - esd_pkg::CH_ZERO);
        end
        if (ch >= "a" && ch <= "f")
        begin
            return int'(ch - "a") + 10;
        end
        if (ch >= "A" && ch <= "F")
        begin
            return int'(ch - "A") + 10;
        end
        return -1;
    endfunction

    function automatic void decode_char(input logic [7:0] ch);
        int owed;
        int hv;
        owed = expected_results.size();
        unique case (dec_mode)
            esd_pkg::MODE_CARET:
            begin
                if (ch == esd_pkg::CH_NUL)
                begin
                    emit_error(ch);
                end
                else
                begin
                    emit_byte((ch == esd_pkg::CH_CARET) ? ch : (ch & esd_pkg::CTRL_MASK));
                    dec_mode = esd_pkg::MODE_NORMAL;
                end
            end
            esd_pkg::MODE_BSLASH:
            begin
                dec_mode = esd_pkg::MODE_NORMAL;
                if (ch == esd_pkg::CH_NUL)
                begin
                    emit_error(ch);
                end
                else if (ch == esd_pkg::CH_ZERO)
                begin
                    dec_acc    = 8'h00;
                    dec_digits = 2'd0;
                    dec_mode   = esd_pkg::MODE_OCT_FIRST;
                end
                else
                begin
                    // Folding in the case bit only merges a letter with its
                    // other case; the zero digit was handled above.
                    unique case (ch | CASE_BIT)
                        "x":
                        begin
                            dec_acc    = 8'h00;
                            dec_digits = 2'd0;
                            dec_mode   = esd_pkg::MODE_HEX_FIRST;
                        end
                        "e": emit_byte(esd_pkg::CH_ESC);
                        "b": emit_byte(esd_pkg::CH_BS);
                        "r": emit_byte(esd_pkg::CH_CR);
                        "n": emit_byte(esd_pkg::CH_LF);
                        "f": emit_byte(esd_pkg::CH_FF);
                        "s": emit_byte(esd_pkg::CH_SPACE);
                        "t": emit_byte(esd_pkg::CH_TAB);
                        "v": emit_byte(esd_pkg::CH_VT);
                        default: emit_byte(ch);
                    endcase
                end
            end
            esd_pkg::MODE_OCT_FIRST, esd_pkg::MODE_OCT:
            begin
                // Eight and nine pass the first-digit check but end the run.
                if (dec_mode == esd_pkg::MODE_OCT_FIRST
                    && !(ch >= esd_pkg::CH_ZERO && ch <= esd_pkg::CH_NINE))
                begin
                    emit_error(ch);
                end
                else if (ch >= esd_pkg::CH_ZERO && ch <= esd_pkg::CH_SEVEN)
                begin
                    dec_acc    = (dec_acc << 3) + (ch - esd_pkg::CH_ZERO);
                    dec_digits = dec_digits + 2'd1;
                    dec_mode   = esd_pkg::MODE_OCT;
                    if (dec_digits >= 2'd3)
                    begin
                        flush_run();
                    end
                end
                else
                begin
                    flush_run();
                    plain_char(ch);
                end
            end
            esd_pkg::MODE_HEX_FIRST, esd_pkg::MODE_HEX:
            begin
                hv = hex_digit_value(ch);
                if (dec_mode == esd_pkg::MODE_HEX_FIRST && hv < 0)
                begin
                    emit_error(ch);
                end
                else if (hv >= 0)
                begin
                    dec_acc    = (dec_acc << 4) + hv[7:0];
                    dec_digits = dec_digits + 2'd1;
                    dec_mode   = esd_pkg::MODE_HEX;
                    if (dec_digits >= 2'd2)
                    begin
                        flush_run();
                    end
                end
                else
                begin
                    flush_run();
                    plain_char(ch);
                end
            end
            esd_pkg::MODE_DISCARD:
            begin
                if (ch == esd_pkg::CH_NUL)
                begin
                    dec_mode  = esd_pkg::MODE_NORMAL;
                    dec_count = 8'h00;
                end
            end
            default: plain_char(ch);
        endcase
        if (expected_results.size() > owed)
        begin
            expected_results[expected_results.size() - 1].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Offers one source byte, with random idle cycles ahead of it, and
    // predicts its results once the transaction is accepted.
    task automatic send_char(input logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= ch;
        do @(posedge clk); while (!in_ch.ready);
        if (dec_mode != esd_pkg::MODE_DISCARD)
        begin
            decoded_inputs++;
        end
        decode_char(ch);
    endtask

    // Stops offering bytes and waits until every expected result has come.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    // Result side ready, with random stalls and the long hold-off.
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= rst_n && !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each result transaction with the oldest expected result.
    always @(posedge clk)
    begin
        esd_pkg::result_t actual;
        esd_pkg::result_t wanted;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            actual.out_byte = out_ch.out_byte;
            actual.status   = out_ch.status;
            actual.length   = out_ch.length;
            actual.last     = out_ch.last;
            if (expected_results.size() == 0)
            begin
                if (mismatch_count < REPORT_MAX)
                begin
                    $display("%0t: unexpected result byte=%h status=%0d length=%0d last=%0d",
                             $realtime, actual.out_byte, actual.status, actual.length,
                             actual.last);
                end
                mismatch_count++;
            end
            else
            begin
                wanted = expected_results.pop_front();
                if (actual !== wanted)
                begin
                    if (mismatch_count < REPORT_MAX)
                    begin
                        $display({"%0t: result differs: expected byte=%h status=%0d ",
                                  "length=%0d last=%0d, got byte=%h status=%0d ",
                                  "length=%0d last=%0d"},
                                 $realtime, wanted.out_byte, wanted.status, wanted.length,
                                 wanted.last, actual.out_byte, actual.status, actual.length,
                                 actual.last);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any transaction.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    function automatic logic [7:0] ordinary_char();
        logic [7:0] ch;
        do ch = 8'($urandom_range(1, 255));
        while (ch == esd_pkg::CH_CARET || ch == esd_pkg::CH_BSLASH);
        return ch;
    endfunction

    function automatic logic [7:0] hex_char(input int value);
        if (value < 10)
        begin
            return esd_pkg::CH_ZERO + 8'(value);
        end
        return ($urandom_range(1) ? "a" : "A") + 8'(value - 10);
    endfunction

    // Sends one well-formed token most of the time, else a broken escape or
    // a raw byte.
    task automatic send_token();
        int pick;
        int run;
        logic [7:0] letter;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            send_char(ordinary_char());
        end
        else if (pick < 45)
        begin
            send_char(esd_pkg::CH_CARET);
            send_char(8'($urandom_range(1, 255)));
        end
        else if (pick < 65)
        begin
            letter = escape_letters[$urandom_range(7)];
            if ($urandom_range(1))
            begin
                letter = letter & ~CASE_BIT;
            end
            send_char(esd_pkg::CH_BSLASH);
            send_char(letter);
        end
        else if (pick < 73)
        begin
            send_char(esd_pkg::CH_BSLASH);
            send_char(8'($urandom_range(1, 255)));
        end
        else if (pick < 83)
        begin
            send_char(esd_pkg::CH_BSLASH);
            send_char(esd_pkg::CH_ZERO);
            if ($urandom_range(9) == 0)
            begin
                send_char(esd_pkg::CH_NINE - 8'($urandom_range(1)));
            end
            else
            begin
                run = $urandom_range(1, 3);
                repeat (run) send_char(esd_pkg::CH_ZERO + 8'($urandom_range(7)));
            end
        end
        else if (pick < 93)
        begin
            send_char(esd_pkg::CH_BSLASH);
            send_char($urandom_range(1) ? "x" : "X");
            run = $urandom_range(1, 2);
            repeat (run) send_char(hex_char($urandom_range(15)));
        end
        else if (pick < 97)
        begin
            send_char(esd_pkg::CH_BSLASH);
            send_char($urandom_range(1) ? esd_pkg::CH_ZERO : "x");
            send_char(8'($urandom_range(1, 255)));
        end
        else
        begin
            send_char(8'($urandom_range(255)));
        end
    endtask

    // One string of random tokens, sometimes with a trailing escape char.
    task automatic send_random_string();
        int tokens;
        tokens = $urandom_range(12);
        repeat (tokens) send_token();
        if ($urandom_range(19) == 0)
        begin
            send_char($urandom_range(1) ? esd_pkg::CH_CARET : esd_pkg::CH_BSLASH);
        end
        send_char(esd_pkg::CH_NUL);
    endtask

    // Each special case in turn, with the extremes of the byte values.
    task automatic test_directed();
        logic [7:0] seq [$];
        seq = '{esd_pkg::CH_BSLASH, esd_pkg::CH_ZERO, "3", esd_pkg::CH_SEVEN,
                esd_pkg::CH_SEVEN,
                esd_pkg::CH_BSLASH, esd_pkg::CH_ZERO, "8",
                esd_pkg::CH_CARET, esd_pkg::CH_CARET,
                esd_pkg::CH_CARET, esd_pkg::BYTE_MAX,
                esd_pkg::CH_NUL,
                esd_pkg::CH_BSLASH, "x", "f", "F",
                esd_pkg::CH_BSLASH, "X", "A", esd_pkg::CH_NUL,
                esd_pkg::CH_BSLASH, "x", "g", 8'h01, esd_pkg::CH_NUL,
                esd_pkg::CH_BSLASH, esd_pkg::CH_NUL,
                esd_pkg::CH_CARET, esd_pkg::CH_NUL,
                esd_pkg::CH_BSLASH, esd_pkg::CH_ZERO, esd_pkg::CH_NUL};
        foreach (seq[i])
        begin
            send_char(seq[i]);
        end
        drain_results();
    endtask

    task automatic test_random_traffic(input int target);
        int start;
        start = decoded_inputs;
        while (decoded_inputs - start < target)
        begin
            send_random_string();
        end
        drain_results();
    endtask

    // A string longer than 255 decoded bytes checks that the length saturates.
    task automatic test_length_saturation();
        repeat (300) send_char(ordinary_char());
        send_char(esd_pkg::CH_NUL);
        drain_results();
    endtask

    // The result side holds off while bytes keep coming, so the result queue
    // fills and the input stalls.
    task automatic test_backpressure();
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
            begin
                repeat (40) send_token();
                send_char(esd_pkg::CH_NUL);
            end
        join
        drain_results();
    endtask

    // Test sequence.
    initial
    begin
        mismatch_count = 0;
        decoded_inputs = 0;
        send_idle_pct  = 18;
        recv_stall_pct <= 50;
        rx_hold        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.in_byte  <= 8'h00;
        rst_n          <= 1'b0;
        dec_mode       = esd_pkg::MODE_NORMAL;
        dec_acc        = 8'h00;
        dec_digits     = 2'd0;
        dec_count      = 8'h00;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(220);

        send_idle_pct  = 50;
        recv_stall_pct <= 18;
        test_random_traffic(220);

        send_idle_pct  = 0;
        recv_stall_pct <= 0;
        test_random_traffic(220);
        test_length_saturation();
        test_backpressure();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
